### sv/cam_pkg.sv
package cam_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W      = 32;
    localparam int PLEN_W      = 6;
    localparam int USED_W      = 9;
    localparam int OPC_W       = 2;

    localparam logic [PLEN_W-1:0] PLEN_MAX = PLEN_W'(ADDR_W);

    typedef enum logic [OPC_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [PLEN_W-1:0] plen;
        logic [ADDR_W-1:0] addr;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic              matched;
        logic              status;
        logic [USED_W-1:0] entries_used;
    } t_result;

    // Leading-bit compare of two addresses under a stored prefix length (0..32).
    function automatic logic prefix_hit(input logic [ADDR_W-1:0] a,
                                        input logic [ADDR_W-1:0] b,
                                        input logic [PLEN_W-1:0] plen);
        logic [ADDR_W-1:0] mask;
        if (plen == '0) begin
            mask = '0;
        end else if (plen >= PLEN_MAX) begin
            mask = '1;
        end else begin
            mask = {ADDR_W{1'b1}} << (PLEN_MAX - plen);
        end
        return ((a & mask) == (b & mask));
    endfunction

endpackage

### sv/cam_table.sv
module cam_table (
    input  logic              i_clk,
    input  cam_pkg::t_mem_req i_req,
    output cam_pkg::t_entry   o_rdata
);

    cam_pkg::t_entry mem [cam_pkg::TABLE_DEPTH];
    cam_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/cam_ctrl.sv
module cam_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [cam_pkg::OPC_W-1:0]   i_opcode,
    input  logic [cam_pkg::ADDR_W-1:0]  i_address,
    input  logic [cam_pkg::PLEN_W-1:0]  i_prefix_len,
    output logic                        o_res_valid,
    input  logic                        i_res_take,
    output cam_pkg::t_result            o_res,
    output cam_pkg::t_mem_req           o_mem_req,
    input  cam_pkg::t_entry             i_mem_rdata
);

    cam_pkg::t_state                 r_state, n_state;
    logic [cam_pkg::CNT_W-1:0]       r_count, n_count;
    logic [cam_pkg::IDX_W-1:0]       r_idx, n_idx;
    logic                            r_issued_all, n_issued_all;
    logic                            r_cmp_v, n_cmp_v;
    logic                            r_cmp_last, n_cmp_last;
    logic [cam_pkg::ADDR_W-1:0]      r_query, n_query;
    cam_pkg::t_result                r_res, n_res;

    logic                            in_acc;
    logic                            rd_en;
    logic                            rd_last;
    logic                            hit;
    logic                            full;
    cam_pkg::t_opcode                opc;
    logic [cam_pkg::PLEN_W-1:0]      plen_sat;

    assign opc      = cam_pkg::t_opcode'(i_opcode);
    assign in_acc   = i_in_valid && !o_in_stall;
    assign full     = (r_count == cam_pkg::CNT_W'(cam_pkg::TABLE_DEPTH));
    assign plen_sat = (i_prefix_len > cam_pkg::PLEN_MAX) ? cam_pkg::PLEN_MAX : i_prefix_len;
    assign rd_last  = (cam_pkg::CNT_W'(r_idx) == (r_count - cam_pkg::CNT_W'(1)));
    assign hit      = cam_pkg::prefix_hit(r_query, i_mem_rdata.addr, i_mem_rdata.plen);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            cam_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (opc == cam_pkg::OP_LOOKUP && r_count != '0) begin
                        n_state = cam_pkg::S_SCAN;
                    end else begin
                        n_state = cam_pkg::S_DONE;
                    end
                end
            end
            cam_pkg::S_SCAN: begin
                if (r_cmp_v && (hit || r_cmp_last)) begin
                    n_state = cam_pkg::S_DONE;
                end
            end
            cam_pkg::S_DONE: begin
                if (i_res_take) begin
                    n_state = cam_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cam_pkg::S_IDLE;
            end
        endcase
    end

    // State decoded outputs.
    always_comb begin
        o_in_stall  = 1'b1;
        o_res_valid = 1'b0;
        rd_en       = 1'b0;
        case (r_state)
            cam_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
            end
            cam_pkg::S_SCAN: begin
                rd_en = !r_issued_all;
            end
            cam_pkg::S_DONE: begin
                o_res_valid = 1'b1;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // Table access and result datapath.
    always_comb begin
        n_count      = r_count;
        n_idx        = r_idx;
        n_issued_all = r_issued_all;
        n_cmp_v      = 1'b0;
        n_cmp_last   = 1'b0;
        n_query      = r_query;
        n_res        = r_res;

        o_mem_req.we          = 1'b0;
        o_mem_req.waddr       = cam_pkg::IDX_W'(r_count);
        o_mem_req.wdata.addr  = i_address;
        o_mem_req.wdata.plen  = plen_sat;
        o_mem_req.re          = rd_en;
        o_mem_req.raddr       = r_idx;

        if (r_state == cam_pkg::S_IDLE && in_acc) begin
            n_query         = i_address;
            n_res.matched   = 1'b0;
            n_res.status    = 1'b0;
            n_idx           = '0;
            n_issued_all    = 1'b0;
            case (opc)
                cam_pkg::OP_CLEAR: begin
                    n_count = '0;
                end
                cam_pkg::OP_APPEND: begin
                    if (full) begin
                        n_res.status = 1'b1;
                    end else begin
                        o_mem_req.we = 1'b1;
                        n_count      = r_count + cam_pkg::CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
            n_res.entries_used = cam_pkg::USED_W'(n_count);
        end

        if (r_state == cam_pkg::S_SCAN) begin
            n_cmp_v    = rd_en;
            n_cmp_last = rd_en && rd_last;
            if (rd_en) begin
                n_idx = r_idx + cam_pkg::IDX_W'(1);
                if (rd_last) begin
                    n_issued_all = 1'b1;
                end
            end
            if (r_cmp_v && hit) begin
                n_res.matched = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cam_pkg::S_IDLE;
            r_count <= '0;
            r_cmp_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_cmp_v <= n_cmp_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_issued_all <= n_issued_all;
        r_cmp_last   <= n_cmp_last;
        r_query      <= n_query;
        r_res        <= n_res;
    end

    assign o_res = r_res;

endmodule

### sv/cidr_allowlist_match.sv
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_opcode, i_address, i_prefix_len
// output    out        o_out_valid / i_out_stall o_matched, o_status, o_entries_used
//
// A clear, append or unused opcode produces its result without a table walk.
// A lookup over N stored entries walks them in order: the table has one read port
// and the walk compares one entry per cycle, stopping at the first hit.
// Reset zeroes the entry count and the control state; table contents are not cleared.
// One result can wait in the output register while the next item is processed.
module cidr_allowlist_match (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [cam_pkg::OPC_W-1:0]   i_opcode,
    input  logic [cam_pkg::ADDR_W-1:0]  i_address,
    input  logic [cam_pkg::PLEN_W-1:0]  i_prefix_len,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_matched,
    output logic                        o_status,
    output logic [cam_pkg::USED_W-1:0]  o_entries_used
);

    cam_pkg::t_mem_req mem_req;
    cam_pkg::t_entry   mem_rdata;
    cam_pkg::t_result  res;
    logic              res_valid;
    logic              res_take;

    logic              r_out_valid, n_out_valid;
    cam_pkg::t_result  r_out, n_out;

    cam_table u_table (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    cam_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_address    (i_address),
        .i_prefix_len (i_prefix_len),
        .o_res_valid  (res_valid),
        .i_res_take   (res_take),
        .o_res        (res),
        .o_mem_req    (mem_req),
        .i_mem_rdata  (mem_rdata)
    );

    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (res_take) begin
            n_out_valid = 1'b1;
            n_out       = res;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid    = r_out_valid;
    assign o_matched      = r_out.matched;
    assign o_status       = r_out.status;
    assign o_entries_used = r_out.entries_used;

    // An accepted item keeps the input side busy until its result moves on.
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after a transfer");

    // A result handed over always lands in the output register.
    a_take_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_take |=> (r_out_valid && r_out == $past(res)))
        else $error("result lost on the way to the output register");

    // A dropped append never reports a match.
    a_status_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_status && o_matched))
        else $error("status and matched both set");

    // The count never exceeds the table size.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_entries_used <= cam_pkg::USED_W'(cam_pkg::TABLE_DEPTH)))
        else $error("entry count out of range");

endmodule

### tb/sv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the prefix table.  It computes the expected verdict
    // of every transfer on the input side and checks the output side.
    class allowlist_shadow;
        logic [cam_pkg::ADDR_W-1:0] net_addr [cam_pkg::TABLE_DEPTH];
        logic [cam_pkg::PLEN_W-1:0] net_plen [cam_pkg::TABLE_DEPTH];
        int unsigned                used;
        cam_pkg::t_result           pending[$];
        int unsigned                mismatches;
        int unsigned                checked;
        int unsigned                hits;
        int unsigned                drops;

        function new();
            used       = 0;
            mismatches = 0;
            checked    = 0;
            hits       = 0;
            drops      = 0;
        endfunction

        static function logic [cam_pkg::ADDR_W-1:0] mask_of(int unsigned p);
            if (p == 0) begin
                return '0;
            end
            return {cam_pkg::ADDR_W{1'b1}} << (cam_pkg::ADDR_W - p);
        endfunction

        function void note_item(cam_pkg::t_opcode op, logic [cam_pkg::ADDR_W-1:0] addr,
                                logic [cam_pkg::PLEN_W-1:0] plen);
            cam_pkg::t_result           want;
            logic [cam_pkg::ADDR_W-1:0] mask;
            want = '0;
            case (op)
                cam_pkg::OP_CLEAR: begin
                    used = 0;
                end
                cam_pkg::OP_APPEND: begin
                    if (used >= cam_pkg::TABLE_DEPTH) begin
                        want.status = 1'b1;
                    end else begin
                        net_addr[used] = addr;
                        net_plen[used] = (plen > cam_pkg::ADDR_W) ?
                                         cam_pkg::PLEN_W'(cam_pkg::ADDR_W) : plen;
                        used++;
                    end
                end
                cam_pkg::OP_LOOKUP: begin
                    for (int i = 0; i < used; i++) begin
                        mask = mask_of(net_plen[i]);
                        if ((addr & mask) == (net_addr[i] & mask)) begin
                            want.matched = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
            want.entries_used = cam_pkg::USED_W'(used);
            pending.push_back(want);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_verdict(cam_pkg::t_result got);
            cam_pkg::t_result want;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending: %p", got));
                return;
            end
            want = pending.pop_front();
            checked++;
            if (want.matched) begin
                hits++;
            end
            if (want.status) begin
                drops++;
            end
            if (got.matched != want.matched) begin
                report_mismatch($sformatf("result %0d matched %0b, expected %0b",
                                          checked, got.matched, want.matched));
            end
            if (got.status != want.status) begin
                report_mismatch($sformatf("result %0d status %0b, expected %0b",
                                          checked, got.status, want.status));
            end
            if (got.entries_used != want.entries_used) begin
                report_mismatch($sformatf("result %0d entries_used %0d, expected %0d",
                                          checked, got.entries_used, want.entries_used));
            end
        endtask
    endclass

    localparam int QUIET_LIMIT = 2000;

    logic                        i_clk;
    logic                        i_rst_n      = 1'b0;
    logic                        i_in_valid   = 1'b0;
    logic                        o_in_stall;
    cam_pkg::t_opcode            i_opcode     = cam_pkg::OP_CLEAR;
    logic [cam_pkg::ADDR_W-1:0]  i_address    = '0;
    logic [cam_pkg::PLEN_W-1:0]  i_prefix_len = '0;
    logic                        o_out_valid;
    logic                        i_out_stall  = 1'b0;
    logic                        o_matched;
    logic                        o_status;
    logic [cam_pkg::USED_W-1:0]  o_entries_used;

    allowlist_shadow   shadow;
    bit                steady       = 1'b0;
    int unsigned       items_sent   = 0;
    int unsigned       taken        = 0;

    // Entries as the stimulus side sees them, used to aim lookups.
    logic [cam_pkg::ADDR_W-1:0] net_log_addr[$];
    logic [cam_pkg::PLEN_W-1:0] net_log_plen[$];

    cidr_allowlist_match dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_address      (i_address),
        .i_prefix_len   (i_prefix_len),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_matched      (o_matched),
        .o_status       (o_status),
        .o_entries_used (o_entries_used)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic send_item(cam_pkg::t_opcode op, logic [cam_pkg::ADDR_W-1:0] addr,
                             logic [cam_pkg::PLEN_W-1:0] plen);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_address    <= addr;
        i_prefix_len <= plen;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        shadow.note_item(op, addr, plen);
        items_sent++;
        if (op == cam_pkg::OP_CLEAR) begin
            net_log_addr.delete();
            net_log_plen.delete();
        end else if (op == cam_pkg::OP_APPEND &&
                     net_log_addr.size() < cam_pkg::TABLE_DEPTH) begin
            net_log_addr.push_back(addr);
            net_log_plen.push_back(plen);
        end
    endtask

    function automatic logic [cam_pkg::PLEN_W-1:0] pick_plen();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return cam_pkg::PLEN_W'($urandom_range(cam_pkg::ADDR_W + 1, 63));
        end
        return cam_pkg::PLEN_W'($urandom_range(1, cam_pkg::ADDR_W));
    endfunction

    // Mostly addresses inside a stored prefix, or one bit off its last
    // prefix bit; the rest are fully random.
    function automatic logic [cam_pkg::ADDR_W-1:0] probe_addr();
        int unsigned                k;
        int unsigned                p;
        logic [cam_pkg::ADDR_W-1:0] mask;
        logic [cam_pkg::ADDR_W-1:0] pick;
        if (net_log_addr.size() == 0 || $urandom_range(0, 3) == 0) begin
            return $urandom;
        end
        k = $urandom_range(0, net_log_addr.size() - 1);
        p = (net_log_plen[k] > cam_pkg::ADDR_W) ? cam_pkg::ADDR_W : net_log_plen[k];
        mask = allowlist_shadow::mask_of(p);
        pick = (net_log_addr[k] & mask) | ($urandom & ~mask);
        if (p != 0 && $urandom_range(0, 1) == 1) begin
            pick[cam_pkg::ADDR_W - p] = ~pick[cam_pkg::ADDR_W - p];
        end
        return pick;
    endfunction

    task automatic run_burst(bit fill);
        int unsigned n_app;
        int unsigned n_look;
        if (fill || $urandom_range(0, 9) < 4) begin
            send_item(cam_pkg::OP_CLEAR, $urandom, cam_pkg::PLEN_W'($urandom));
        end
        n_app = fill ? cam_pkg::TABLE_DEPTH + $urandom_range(2, 6) : $urandom_range(0, 24);
        repeat (n_app) send_item(cam_pkg::OP_APPEND, $urandom, pick_plen());
        n_look = $urandom_range(5, 30);
        repeat (n_look) begin
            if ($urandom_range(0, 19) == 0) begin
                send_item(cam_pkg::t_opcode'($urandom_range(0, 3)), $urandom,
                          cam_pkg::PLEN_W'($urandom));
            end else begin
                send_item(cam_pkg::OP_LOOKUP, probe_addr(), cam_pkg::PLEN_W'($urandom));
            end
        end
    endtask

    initial begin
        int unsigned bursts;
        shadow = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(cam_pkg::OP_LOOKUP, 32'h0000_0000, 6'd0);
        send_item(cam_pkg::OP_NONE,   32'h1234_5678, 6'd5);
        send_item(cam_pkg::OP_APPEND, 32'hC0A8_0000, 6'd16);
        send_item(cam_pkg::OP_LOOKUP, 32'hC0A8_FFFF, 6'd0);
        send_item(cam_pkg::OP_LOOKUP, 32'hC0A9_0000, 6'd0);
        // A prefix length above 32 is kept as an exact match.
        send_item(cam_pkg::OP_APPEND, 32'h0A00_0001, 6'd63);
        send_item(cam_pkg::OP_LOOKUP, 32'h0A00_0001, 6'd0);
        send_item(cam_pkg::OP_LOOKUP, 32'h0A00_0000, 6'd63);
        send_item(cam_pkg::OP_APPEND, 32'hFFFF_FFFF, 6'd32);
        send_item(cam_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 6'd32);
        send_item(cam_pkg::OP_LOOKUP, 32'hFFFF_FFFE, 6'd0);
        send_item(cam_pkg::OP_APPEND, 32'h8000_0000, 6'd1);
        send_item(cam_pkg::OP_LOOKUP, 32'h7FFF_FFFF, 6'd0);
        send_item(cam_pkg::OP_LOOKUP, 32'h8000_0001, 6'd0);
        send_item(cam_pkg::OP_APPEND, 32'h1234_5678, 6'd31);
        send_item(cam_pkg::OP_LOOKUP, 32'h1234_5679, 6'd0);
        send_item(cam_pkg::OP_CLEAR,  32'h0000_0000, 6'd0);
        send_item(cam_pkg::OP_LOOKUP, 32'hC0A8_0001, 6'd0);
        // A zero-length prefix matches every address.
        send_item(cam_pkg::OP_APPEND, 32'h0000_0000, 6'd0);
        send_item(cam_pkg::OP_LOOKUP, 32'hDEAD_BEEF, 6'd0);
        send_item(cam_pkg::OP_NONE,   32'hFFFF_FFFF, 6'd63);
        send_item(cam_pkg::OP_CLEAR,  32'hFFFF_FFFF, 6'd63);
        send_item(cam_pkg::OP_LOOKUP, 32'hDEAD_BEEF, 6'd0);

        bursts = 0;
        while (items_sent < 1550) begin
            steady = ($urandom_range(0, 3) == 0);
            run_burst(bursts == 2 || bursts == 20);
            bursts++;
        end
        i_in_valid <= 1'b0;
        steady = 1'b0;

        while (shadow.pending.size() != 0) @(posedge i_clk);
        repeat (cam_pkg::TABLE_DEPTH + 16) @(posedge i_clk);

        $display("Sent %0d items in %0d bursts, two of them filling the table past capacity.",
                 items_sent, bursts);
        $display("Checked %0d results: %0d lookup hits, %0d appends dropped on a full table.",
                 shadow.checked, shadow.hits, shadow.drops);
        if (shadow.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Result side: a random hold-off before each transfer, and twice a long
    // one so the block fills up and stalls its input.
    initial begin
        int unsigned hold;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            hold = steady ? 0 : $urandom_range(0, 4);
            if (taken == 300 || taken == 900) begin
                hold = 80;
            end
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            shadow.check_verdict(cam_pkg::t_result'({o_matched, o_status, o_entries_used}));
            taken++;
        end
    end

    initial begin
        int unsigned quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet == QUIET_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", quiet);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

endmodule
